[rtl/tamf_pkg.sv]
// Shared constants, payload types and control types of the trimmed-mean filter.
package tamf_pkg;

  localparam int MaxWindow = 32;
  localparam int SampleW   = 16;
  localparam int MinLen    = 3;
  localparam int LenReset  = 10;

  localparam int LenW    = 6;
  localparam int SlotW   = $clog2(MaxWindow);
  localparam int CntW    = $clog2(MaxWindow + 1);
  localparam int SumW    = SampleW + $clog2(MaxWindow);
  localparam int DivCntW = $clog2(SumW);

  localparam int ApbDataW = 32;
  localparam int AddrW    = 3;

  // register index, taken from paddr above the byte offset
  typedef enum logic [AddrW-3:0] {
    RegWindowLength = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StLoad,
    StDiv,
    StHold
  } state_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_x;
    logic signed [SampleW-1:0] sample_y;
    logic signed [SampleW-1:0] sample_z;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] mean_x;
    logic signed [SampleW-1:0] mean_y;
    logic signed [SampleW-1:0] mean_z;
  } out_word_t;

  typedef struct packed {
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    logic             rd_en;
    logic             rd_first;
    logic [SlotW-1:0] rd_addr;
    logic             div_start;
    logic [CntW-1:0]  divisor;
  } lane_ctrl_t;

endpackage

[rtl/tamf_div.sv]
// Radix-2 restoring signed divider, one quotient bit per cycle, truncates toward zero.
module tamf_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [tamf_pkg::SumW-1:0]  dividend_i,
  input  logic        [tamf_pkg::CntW-1:0]  divisor_i,
  output logic                              done_o,
  output logic signed [tamf_pkg::SampleW-1:0] quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [tamf_pkg::DivCntW-1:0]      cnt_q;
  logic                              neg_q;
  logic [tamf_pkg::CntW-1:0]         rem_q;
  logic [tamf_pkg::SumW-1:0]         quo_q;

  logic [tamf_pkg::CntW:0]           rem_sh;
  logic [tamf_pkg::CntW:0]           rem_sub;
  logic                              ge;
  logic [tamf_pkg::SumW-1:0]         mag;
  logic [tamf_pkg::SumW-1:0]         res;

  always_comb begin
    rem_sh  = {rem_q, quo_q[tamf_pkg::SumW-1]};
    ge      = rem_sh >= {1'b0, divisor_i};
    rem_sub = rem_sh - {1'b0, divisor_i};
    mag     = dividend_i[tamf_pkg::SumW-1] ? (~dividend_i + 1'b1) : dividend_i;
    res     = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= tamf_pkg::DivCntW'(tamf_pkg::SumW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[tamf_pkg::SumW-1];
      quo_q <= mag;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[tamf_pkg::CntW-1:0] : rem_sh[tamf_pkg::CntW-1:0];
      quo_q <= {quo_q[tamf_pkg::SumW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = res[tamf_pkg::SampleW-1:0];

endmodule

[rtl/tamf_lane.sv]
// One axis lane: window memory, sum/min/max scan and divider.
module tamf_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tamf_pkg::lane_ctrl_t                ctrl_i,
  input  logic signed [tamf_pkg::SampleW-1:0] sample_i,
  output logic signed [tamf_pkg::SampleW-1:0] mean_o,
  output logic                                done_o
);

  logic signed [tamf_pkg::SampleW-1:0] mem_q [tamf_pkg::MaxWindow];
  logic signed [tamf_pkg::SampleW-1:0] rd_data_q;
  logic                                rd_vld_q;
  logic                                rd_first_q;

  logic signed [tamf_pkg::SumW-1:0]    sum_q;
  logic signed [tamf_pkg::SampleW-1:0] lo_q;
  logic signed [tamf_pkg::SampleW-1:0] hi_q;
  logic signed [tamf_pkg::SumW-1:0]    trimmed;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= sample_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.rd_en;
      rd_first_q <= ctrl_i.rd_en & ctrl_i.rd_first;
    end
  end

  // running sum, min and max over the window
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (rd_first_q) begin
        sum_q <= tamf_pkg::SumW'(rd_data_q);
        lo_q  <= rd_data_q;
        hi_q  <= rd_data_q;
      end else begin
        sum_q <= sum_q + tamf_pkg::SumW'(rd_data_q);
        if (rd_data_q < lo_q) begin
          lo_q <= rd_data_q;
        end
        if (rd_data_q > hi_q) begin
          hi_q <= rd_data_q;
        end
      end
    end
  end

  assign trimmed = sum_q - tamf_pkg::SumW'(lo_q) - tamf_pkg::SumW'(hi_q);

  tamf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (trimmed),
    .divisor_i  (ctrl_i.divisor),
    .done_o     (done_o),
    .quotient_o (mean_o)
  );

endmodule

[rtl/three_axis_trimmed_mean_filter.sv]
// Top level of the three-axis trimmed-mean filter: control, config register, output stage.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_word_i) carries one x/y/z sample word.
//   A word is taken at a clock edge with in_valid_i high and in_stall_o low.
// - Output channel (out_valid_o / out_stall_i / out_word_o) carries one mean word.
// - Each axis lane keeps its own window memory of up to 32 samples in arrival order.
//   The three lanes scan and divide side by side; the output register merges them.
// - Words that do not yet fill the window give no result and leave the control idle.
// - A word that gives a result: the window scan (one memory read per cycle), a
//   drain state, a load state, the divide phase until all three dividers are done
//   and a merge into the output register; the next word can be taken after the merge.
//   The result shows on out_valid_o at that same point.
// - The output register parts the two sides: a new word is taken while a result
//   still waits. If the receiver stalls, the finished result waits in the lanes'
//   dividers and in_stall_o stays high until the output register frees up.
// - window_length sits at APB address 0 (reset 10); values below 3 act as 3 and
//   above 32 as 32. Writing it restarts the fill. Write only while idle.
// - Reset clears the fill state and control; window memories are not cleared,
//   since every entry is written before it is read.
module three_axis_trimmed_mean_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tamf_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tamf_pkg::out_word_t               out_word_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tamf_pkg::AddrW-1:0]        paddr,
  input  logic [tamf_pkg::ApbDataW-1:0]     pwdata,
  output logic [tamf_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  tamf_pkg::state_e state_q, state_d;

  logic [tamf_pkg::LenW-1:0]  len_q;
  logic [tamf_pkg::SlotW-1:0] slot_q;
  logic                       filled_q;
  logic [tamf_pkg::SlotW-1:0] rd_idx_q;
  logic                       out_valid_q;
  tamf_pkg::out_word_t        out_word_q;

  logic                       cfg_sel;
  logic                       cfg_wr;
  logic [tamf_pkg::CntW-1:0]  n_eff;
  logic [tamf_pkg::SlotW-1:0] slot_wr;
  logic [tamf_pkg::CntW-1:0]  slot_inc;
  logic                       wrap;
  logic                       result_due;
  logic                       accept;
  logic                       scan_last;
  logic                       out_free;
  logic                       out_load;
  logic                       done_all;

  tamf_pkg::lane_ctrl_t       ctrl;
  logic                       done_x, done_y, done_z;
  logic signed [tamf_pkg::SampleW-1:0] mean_x, mean_y, mean_z;

  // ---------------------------------------------------------------------------
  // APB register
  // ---------------------------------------------------------------------------
  assign cfg_sel = paddr[tamf_pkg::AddrW-1:2] == tamf_pkg::RegWindowLength;
  assign cfg_wr  = psel & penable & pwrite & cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? tamf_pkg::ApbDataW'(len_q) : '0;

  // clamp to 3 .. MaxWindow
  always_comb begin
    if (int'(len_q) < tamf_pkg::MinLen) begin
      n_eff = tamf_pkg::CntW'(tamf_pkg::MinLen);
    end else if (int'(len_q) > tamf_pkg::MaxWindow) begin
      n_eff = tamf_pkg::CntW'(tamf_pkg::MaxWindow);
    end else begin
      n_eff = tamf_pkg::CntW'(len_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Ring slot bookkeeping
  // ---------------------------------------------------------------------------
  always_comb begin
    slot_wr    = (tamf_pkg::CntW'(slot_q) >= n_eff) ? '0 : slot_q;
    slot_inc   = tamf_pkg::CntW'(slot_wr) + 1'b1;
    wrap       = slot_inc >= n_eff;
    result_due = filled_q | wrap;
  end

  assign in_stall_o = state_q != tamf_pkg::StIdle;
  assign accept     = in_valid_i & ~in_stall_o;
  assign scan_last  = tamf_pkg::CntW'(rd_idx_q) == (n_eff - 1'b1);
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign done_all   = done_x & done_y & done_z;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      tamf_pkg::StIdle: begin
        if (accept && result_due) begin
          state_d = tamf_pkg::StScan;
        end
      end
      tamf_pkg::StScan: begin
        if (scan_last) begin
          state_d = tamf_pkg::StDrain;
        end
      end
      tamf_pkg::StDrain: state_d = tamf_pkg::StLoad;
      tamf_pkg::StLoad:  state_d = tamf_pkg::StDiv;
      tamf_pkg::StDiv: begin
        if (done_all) begin
          state_d = tamf_pkg::StHold;
        end
      end
      tamf_pkg::StHold: begin
        if (out_free) begin
          state_d = tamf_pkg::StIdle;
        end
      end
      default: state_d = tamf_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl.wr_en     = accept;
    ctrl.wr_addr   = slot_wr;
    ctrl.rd_en     = 1'b0;
    ctrl.rd_first  = 1'b0;
    ctrl.rd_addr   = rd_idx_q;
    ctrl.div_start = 1'b0;
    ctrl.divisor   = n_eff - tamf_pkg::CntW'(2);
    out_load       = 1'b0;
    case (state_q)
      tamf_pkg::StScan: begin
        ctrl.rd_en    = 1'b1;
        ctrl.rd_first = rd_idx_q == '0;
      end
      tamf_pkg::StLoad: ctrl.div_start = 1'b1;
      tamf_pkg::StHold: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tamf_pkg::StIdle;
      len_q       <= tamf_pkg::LenW'(tamf_pkg::LenReset);
      slot_q      <= '0;
      filled_q    <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        len_q    <= pwdata[tamf_pkg::LenW-1:0];
        slot_q   <= '0;
        filled_q <= 1'b0;
      end else if (accept) begin
        if (wrap) begin
          slot_q   <= '0;
          filled_q <= 1'b1;
        end else begin
          slot_q <= slot_inc[tamf_pkg::SlotW-1:0];
        end
      end

      if (state_q == tamf_pkg::StScan) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end else begin
        rd_idx_q <= '0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge the three lane results into one word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.mean_x <= mean_x;
      out_word_q.mean_y <= mean_y;
      out_word_q.mean_z <= mean_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Axis lanes
  // ---------------------------------------------------------------------------
  tamf_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_word_i.sample_x),
    .mean_o   (mean_x),
    .done_o   (done_x)
  );

  tamf_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_word_i.sample_y),
    .mean_o   (mean_y),
    .done_o   (done_y)
  );

  tamf_lane u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (in_word_i.sample_z),
    .mean_o   (mean_z),
    .done_o   (done_z)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tamf_pkg::CntW'(slot_q) < n_eff)
    else $error("write slot outside window");

  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_x == done_y) && (done_y == done_z))
    else $error("lanes out of step");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x |-> state_q == tamf_pkg::StDiv)
    else $error("divider done outside divide phase");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == tamf_pkg::StHold))
    else $error("result word without merge");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !result_due && !cfg_wr) |=> state_q == tamf_pkg::StIdle)
    else $error("scan started before window filled");

endmodule
